### src/eea2_pkg.sv
// shared types, constants and aes helper functions for the eea2 counter-mode cipher
// no dependencies

package eea2_pkg;

    localparam int BLK_BITS = 128;
    localparam int BLK_BYTES = 16;
    localparam int AES_ROUNDS = 10;
    localparam logic [7:0] BEARER_DIR_MASK = 8'hFC;

    typedef logic [BLK_BITS-1:0] blk_t;
    typedef logic [63:0] ctr_t;

    typedef enum logic [2:0] {
        CFG_KEY_HIGH  = 3'd0,
        CFG_KEY_LOW   = 3'd1,
        CFG_COUNT     = 3'd2,
        CFG_BEARER    = 3'd3,
        CFG_DIRECTION = 3'd4
    } cfg_idx_t;

    // requests from the byte unit to the keystream generator
    typedef struct packed {
        logic pop;       // queue head taken
        logic msg_end;   // last byte accepted, counter back to zero
    } back_req_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // byte k of a block sits in the top bits first
    function automatic logic [7:0] blk_byte(input blk_t b, input logic [3:0] k);
        return b[BLK_BITS-1-8*k -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1: r = 8'h01;
            4'd2: r = 8'h02;
            4'd3: r = 8'h04;
            4'd4: r = 8'h08;
            4'd5: r = 8'h10;
            4'd6: r = 8'h20;
            4'd7: r = 8'h40;
            4'd8: r = 8'h80;
            4'd9: r = 8'h1b;
            4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic blk_t key_step(input blk_t rk, input logic [7:0] rc);
        logic [31:0] w [4];
        logic [31:0] t;
        blk_t nk;
        for (int i = 0; i < 4; i++) w[i] = rk[BLK_BITS-1-32*i -: 32];
        t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        nk = {w[0], w[1], w[2], w[3]};
        return nk;
    endfunction

    function automatic blk_t aes_round(input blk_t s, input blk_t rk, input logic last_rnd);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        blk_t o;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[i+4*c] = SBOX[blk_byte(s, 4'((i + 4*((c + i) & 3))))];
        if (!last_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int k = 0; k < 16; k++) o[BLK_BITS-1-8*k -: 8] = t[k];
        return o ^ rk;
    endfunction

endpackage

### src/eea2_aes_core.sv
// iterative aes-128 encryption, one round per cycle with on-the-fly key schedule
// depends on eea2_pkg

module eea2_aes_core
    import eea2_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  logic abort,
    input  blk_t key,
    input  blk_t blk_in,
    output logic busy,
    output logic done,
    output blk_t blk_out
);

    blk_t       s_reg, s_next;
    blk_t       rk_reg, rk_next;
    logic [3:0] rnd_reg, rnd_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    blk_t       nrk;

    always_comb begin
        nrk = key_step(rk_reg, rcon(rnd_reg));
        s_next = s_reg;
        rk_next = rk_reg;
        rnd_next = rnd_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (abort) begin
            busy_next = 1'b0;
        end else if (start) begin
            s_next = blk_in ^ key;
            rk_next = key;
            rnd_next = 4'd1;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            s_next = aes_round(s_reg, nrk, rnd_reg == 4'(AES_ROUNDS));
            rk_next = nrk;
            rnd_next = rnd_reg + 4'd1;
            if (rnd_reg == 4'(AES_ROUNDS)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            rnd_reg <= rnd_next;
        end
        s_reg <= s_next;
        rk_reg <= rk_next;
    end

    assign busy = busy_reg | done_reg;
    assign done = done_reg;
    assign blk_out = s_reg;

endmodule

### src/eea2_ks_gen.sv
// keystream generator: runs the aes core ahead of the byte unit, keeps the
// counter-zero block apart and queues later blocks; depends on eea2_pkg, eea2_aes_core

module eea2_ks_gen
    import eea2_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  blk_t      key,
    input  logic [63:0] ctr_hi,     // count, bearer/direction byte and zero bytes
    input  logic      cfg_flush,
    input  ctr_t      restart_ctr,
    input  back_req_t req,
    output blk_t      blk0,
    output logic      blk0_valid,
    output blk_t      head,
    output logic      head_valid
);

    blk_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    ctr_t       ctr_reg, ctr_next;
    logic       to_blk0_reg, to_blk0_next;
    logic       blk0_valid_reg, blk0_valid_next;
    blk_t       blk0_reg;

    logic eng_busy, eng_done, start, abort, drop, push;
    ctr_t start_ctr;
    blk_t eng_out;

    assign drop = cfg_flush | (req.msg_end & !to_blk0_reg);
    assign abort = drop;
    assign push = eng_done & !drop & !to_blk0_reg;

    always_comb begin
        start = 1'b0;
        start_ctr = ctr_reg;
        to_blk0_next = to_blk0_reg;
        ctr_next = ctr_reg;
        if (!eng_busy && !cfg_flush && !req.msg_end) begin
            if (!blk0_valid_reg) begin
                start = 1'b1;
                start_ctr = '0;
                to_blk0_next = 1'b1;
            end else if (cnt_reg < 2'd2) begin
                start = 1'b1;
                to_blk0_next = 1'b0;
                ctr_next = ctr_reg + 64'd1;
            end
        end
        if (cfg_flush)
            ctr_next = restart_ctr;
        else if (req.msg_end)
            ctr_next = 64'd1;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        blk0_valid_next = blk0_valid_reg;
        if (eng_done && !cfg_flush && to_blk0_reg)
            blk0_valid_next = 1'b1;
        if (cfg_flush)
            blk0_valid_next = 1'b0;
        if (cfg_flush || req.msg_end) begin
            wr_ptr_next = 1'b0;
            rd_ptr_next = 1'b0;
            cnt_next = 2'd0;
        end else begin
            if (push) wr_ptr_next = ~wr_ptr_reg;
            if (req.pop) rd_ptr_next = ~rd_ptr_reg;
            cnt_next = cnt_reg + {1'b0, push} - {1'b0, req.pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
            ctr_reg <= 64'd1;
            to_blk0_reg <= 1'b0;
            blk0_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
            ctr_reg <= ctr_next;
            to_blk0_reg <= to_blk0_next;
            blk0_valid_reg <= blk0_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            q_mem[wr_ptr_reg] <= eng_out;
        if (eng_done && to_blk0_reg)
            blk0_reg <= eng_out;
    end

    eea2_aes_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .abort   (abort),
        .key     (key),
        .blk_in  ({ctr_hi, start_ctr}),
        .busy    (eng_busy),
        .done    (eng_done),
        .blk_out (eng_out)
    );

    assign blk0 = blk0_reg;
    assign blk0_valid = blk0_valid_reg;
    assign head = q_mem[rd_ptr_reg];
    assign head_valid = cnt_reg != 2'd0;

endmodule

### src/eea2_byte_unit.sv
// byte unit: xors each byte with the current keystream block, output register stage
// depends on eea2_pkg

module eea2_byte_unit
    import eea2_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic [7:0] s_data,
    input  logic      s_last,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic [7:0] m_data,
    output logic      m_last,
    input  blk_t      blk0,
    input  logic      blk0_valid,
    input  blk_t      head,
    input  logic      head_valid,
    output back_req_t req,
    output ctr_t      restart_ctr
);

    logic [3:0] off_reg, off_next;
    ctr_t       nxt_reg, nxt_next;
    logic       first_reg, first_next;
    blk_t       cur_reg;
    logic       mv_reg, mv_next;
    logic [7:0] mdata_reg;
    logic       mlast_reg;

    logic need_blk, blk_ok, accept;
    blk_t blk_use;

    assign need_blk = off_reg == 4'd0;
    assign blk_ok = !need_blk || (first_reg ? blk0_valid : head_valid);
    assign s_tready = blk_ok && (!mv_reg || m_tready);
    assign accept = s_tvalid && s_tready;
    assign blk_use = !need_blk ? cur_reg : (first_reg ? blk0 : head);

    always_comb begin
        off_next = off_reg;
        nxt_next = nxt_reg;
        first_next = first_reg;
        mv_next = mv_reg && !m_tready;
        req.pop = 1'b0;
        req.msg_end = 1'b0;
        if (accept) begin
            mv_next = 1'b1;
            off_next = off_reg + 4'd1;
            if (need_blk) begin
                // the block for nxt is now in use
                nxt_next = nxt_reg + 64'd1;
                first_next = 1'b0;
                req.pop = !first_reg;
            end
            if (s_last) begin
                off_next = 4'd0;
                nxt_next = 64'd0;
                first_next = 1'b1;
                req.msg_end = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg <= 4'd0;
            nxt_reg <= 64'd0;
            first_reg <= 1'b1;
            mv_reg <= 1'b0;
        end else begin
            off_reg <= off_next;
            nxt_reg <= nxt_next;
            first_reg <= first_next;
            mv_reg <= mv_next;
        end
        if (accept) begin
            mdata_reg <= s_data ^ blk_byte(blk_use, off_reg);
            mlast_reg <= s_last;
            if (need_blk)
                cur_reg <= blk_use;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_data = mdata_reg;
    assign m_last = mlast_reg;
    // counter-zero block lives apart, so the queue restarts at one then
    assign restart_ctr = first_reg ? 64'd1 : nxt_reg;

endmodule

### src/lte_eea2_aes_ctr_cipher_unit.sv
// lte 128-eea2 (aes-128 counter mode) byte cipher, top level
// result registered in the cycle after the input transfer; one byte per cycle
// while keystream is ready and the output is not stalled; aes core makes 16-byte blocks
// first byte after reset or a config write waits for the counter-zero block
// reset: synchronous active-low aresetn, clears counters, queue and config
// depends on eea2_pkg, eea2_ks_gen, eea2_byte_unit

module lte_eea2_aes_ctr_cipher_unit
    import eea2_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_idx,
    input  logic [63:0] cfg_wr_data
);

    logic [63:0] key_high_reg, key_low_reg;
    logic [31:0] count_reg;
    logic [4:0]  bearer_reg;
    logic        direction_reg;

    back_req_t req;
    ctr_t      restart_ctr;
    blk_t      blk0, head;
    logic      blk0_valid, head_valid;
    logic [7:0] bd_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg <= '0;
            count_reg <= '0;
            bearer_reg <= '0;
            direction_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_wr_idx))
                CFG_KEY_HIGH:  key_high_reg <= cfg_wr_data;
                CFG_KEY_LOW:   key_low_reg <= cfg_wr_data;
                CFG_COUNT:     count_reg <= cfg_wr_data[31:0];
                CFG_BEARER:    bearer_reg <= cfg_wr_data[4:0];
                CFG_DIRECTION: direction_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign bd_byte = {bearer_reg, direction_reg, 2'b00} & BEARER_DIR_MASK;

    eea2_ks_gen u_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .key         ({key_high_reg, key_low_reg}),
        .ctr_hi      ({count_reg, bd_byte, 24'd0}),
        .cfg_flush   (cfg_wr_en),
        .restart_ctr (restart_ctr),
        .req         (req),
        .blk0        (blk0),
        .blk0_valid  (blk0_valid),
        .head        (head),
        .head_valid  (head_valid)
    );

    eea2_byte_unit u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_data      (s_tdata),
        .s_last      (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_data      (m_tdata),
        .m_last      (m_tlast),
        .blk0        (blk0),
        .blk0_valid  (blk0_valid),
        .head        (head),
        .head_valid  (head_valid),
        .req         (req),
        .restart_ctr (restart_ctr)
    );

endmodule

### src/eea2_checker.sv
// port-level checks for the eea2 cipher unit, bound to the top level
// depends on lte_eea2_aes_ctr_cipher_unit

module eea2_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted byte gave no result");

    a_last_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (m_tlast == $past(s_tlast)))
        else $error("last flag lost");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind lte_eea2_aes_ctr_cipher_unit eea2_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/tb_lte_eea2_aes_ctr_cipher_unit.sv
// testbench for the lte 128-eea2 byte cipher: random and directed byte streams,
// keystream predicted by an aes-128 counter-mode model held in a small scoreboard
// depends on eea2_pkg and lte_eea2_aes_ctr_cipher_unit
`timescale 1ns / 100ps

module tb_lte_eea2_aes_ctr_cipher_unit;
    import eea2_pkg::*;

    localparam logic [7:0] SUB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       msg_last;
    } cipher_out_t;

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    class ctr_scoreboard;
        logic [63:0] key_hi, key_lo, blk_num;
        logic [31:0] msg_count;
        logic [4:0]  bearer_id;
        logic        dir_bit;
        logic [7:0]  ks_bytes [16];
        logic [3:0]  offset;
        cipher_out_t pending [$];
        int          n_errors;

        function void clear();
            key_hi = '0; key_lo = '0; blk_num = '0; msg_count = '0;
            bearer_id = '0; dir_bit = 1'b0; offset = '0; n_errors = 0;
            pending.delete();
        endfunction

        function void write_reg(input cfg_idx_t idx, input logic [63:0] val);
            case (idx)
                CFG_KEY_HIGH:  key_hi = val;
                CFG_KEY_LOW:   key_lo = val;
                CFG_COUNT:     msg_count = val[31:0];
                CFG_BEARER:    bearer_id = val[4:0];
                CFG_DIRECTION: dir_bit = val[0];
                default: ;
            endcase
        endfunction

        // aes-128 of the counter block into ks_bytes
        function void encrypt_counter();
            logic [7:0] rk [176];
            logic [7:0] st [16];
            logic [7:0] tt [16];
            logic [7:0] tw [4];
            logic [7:0] rc, f, a0, a1, a2, a3, al;
            logic [127:0] kk, cb;
            kk = {key_hi, key_lo};
            cb = {msg_count, ({bearer_id, dir_bit, 2'b00} & BEARER_DIR_MASK), 24'h0, blk_num};
            for (int i = 0; i < 16; i++) rk[i] = kk[127-8*i -: 8];
            rc = 8'h01;
            for (int i = 4; i < 44; i++) begin
                for (int j = 0; j < 4; j++) tw[j] = rk[4*(i-1)+j];
                if ((i & 3) == 0) begin
                    f = tw[0];
                    tw[0] = SUB[tw[1]] ^ rc; tw[1] = SUB[tw[2]];
                    tw[2] = SUB[tw[3]];      tw[3] = SUB[f];
                    rc = gf_dbl(rc);
                end
                for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ tw[j];
            end
            for (int i = 0; i < 16; i++) st[i] = cb[127-8*i -: 8] ^ rk[i];
            for (int r = 1; r <= 10; r++) begin
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++) tt[i+4*c] = SUB[st[i + 4*((c+i) & 3)]];
                if (r != 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = tt[4*c]; a1 = tt[4*c+1]; a2 = tt[4*c+2]; a3 = tt[4*c+3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        tt[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
                        tt[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
                        tt[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
                        tt[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
                    end
                end
                for (int i = 0; i < 16; i++) st[i] = tt[i] ^ rk[16*r+i];
            end
            for (int i = 0; i < 16; i++) ks_bytes[i] = st[i];
        endfunction

        function void note_byte(input logic [7:0] d, input logic lst);
            cipher_out_t e;
            if (offset == 0) encrypt_counter();
            e.cipher_byte = d ^ ks_bytes[offset];
            e.msg_last = lst;
            pending.push_back(e);
            offset = offset + 4'd1;
            if (offset == 0) blk_num = blk_num + 64'd1;
            if (lst) begin
                blk_num = '0;
                offset = '0;
            end
        endfunction

        function void check_byte(input logic [7:0] d, input logic lst);
            cipher_out_t e;
            if (pending.size() == 0) begin
                $error("unexpected transfer: out_byte %h out_last %b", d, lst);
                n_errors++;
                return;
            end
            e = pending.pop_front();
            if (d !== e.cipher_byte) begin
                $error("out_byte expected %h actual %h", e.cipher_byte, d);
                n_errors++;
            end
            if (lst !== e.msg_last) begin
                $error("out_last expected %b actual %b", e.msg_last, lst);
                n_errors++;
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, s_tlast;
    logic [7:0]  s_tdata;      // [7:0] data_byte
    logic        m_tvalid, m_tready, m_tlast;
    logic [7:0]  m_tdata;      // [7:0] out_byte
    logic        cfg_wr_en;
    logic [2:0]  cfg_wr_idx;
    logic [63:0] cfg_wr_data;

    ctr_scoreboard sb;
    int send_idle_pct, recv_idle_pct;
    bit hold_recv;
    longint cycle_no;

    lte_eea2_aes_ctr_cipher_unit u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycle_no = 0;
        forever begin
            @(posedge aclk);
            cycle_no++;
            if (cycle_no > 400000) begin
                $display("tb_lte_eea2_aes_ctr_cipher_unit: done, errors");
                $finish;
            end
        end
    end

    // receiver side and result checking
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
            m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(d, lst);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        // keystream engine may still be computing ahead
        repeat (40) @(posedge aclk);
    endtask

    // one write cycle, then the task returns with the enable low
    task automatic write_cfg(input cfg_idx_t idx, input logic [63:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic load_setting(input logic [63:0] kh, input logic [63:0] kl,
                                input logic [31:0] cn, input logic [4:0] br,
                                input logic dr);
        wait_drained();
        write_cfg(CFG_KEY_HIGH, kh);
        write_cfg(CFG_KEY_LOW, kl);
        write_cfg(CFG_COUNT, {$urandom, cn});
        write_cfg(CFG_BEARER, {$urandom, $urandom} & 64'hffff_ffff_ffff_ffe0 | br);
        write_cfg(CFG_DIRECTION, {$urandom, $urandom} & ~64'h1 | dr);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_messages(input int n_bytes);
        int left, len;
        left = n_bytes;
        while (left > 0) begin
            // mostly short messages, some crossing several blocks
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(20, 1);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
            left -= len;
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        hold_recv = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        cfg_wr_en = 1'b0; cfg_wr_idx = '0; cfg_wr_data = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero config, extreme bytes, block boundary, single-byte message
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        for (int i = 0; i < 15; i++) send_byte(8'($urandom), 1'b0);
        send_byte(8'h5a, 1'b1);
        send_byte(8'ha5, 1'b1);
        load_setting('1, '1, 32'hffff_ffff, 5'h1f, 1'b1);
        for (int i = 0; i < 5; i++) send_byte(8'($urandom), i == 4);

        // register change in the middle of a block only counts at the next block
        for (int i = 0; i < 4; i++) send_byte(8'($urandom), 1'b0);
        wait_drained();
        write_cfg(CFG_COUNT, 64'h1234_5678);
        // model samples registers at block start, so mirror only from here
        for (int i = 0; i < 14; i++) send_byte(8'($urandom), i == 13);
        // unknown register index is ignored
        wait_drained();
        cfg_wr_en <= 1'b1; cfg_wr_idx <= 3'd7; cfg_wr_data <= '1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;

        send_idle_pct = 32; recv_idle_pct = 57;
        load_setting({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                     5'($urandom), 1'($urandom));
        random_messages(250);

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        fork
            begin
                hold_recv = 1'b1;
                repeat (300) @(posedge aclk);
                hold_recv = 1'b0;
            end
            random_messages(60);
        join

        // sender pauses until everything is back
        wait_drained();
        send_idle_pct = 57; recv_idle_pct = 32;
        load_setting('0, '1, 32'h0, 5'h0, 1'b0);
        random_messages(250);

        send_idle_pct = 0; recv_idle_pct = 0;
        load_setting({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                     5'($urandom), 1'($urandom));
        random_messages(250);

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.n_errors == 0)
            $display("tb_lte_eea2_aes_ctr_cipher_unit: done, clean");
        else
            $display("tb_lte_eea2_aes_ctr_cipher_unit: done, errors");
        $finish;
    end
endmodule
